[src/biv_pkg.sv]
// ----------------------------------------------------------------------------
// biv_pkg: shared types, constants and the CRC helper
// Register indexes, status codes, reset values and the byte-wide CRC-32 step
// used by the boot image verifier.
// ----------------------------------------------------------------------------
package biv_pkg;

   // Field widths
   localparam int unsigned LenW    = 20;
   localparam int unsigned WordW   = 32;
   localparam int unsigned ByteW   = 8;
   localparam int unsigned StatusW = 3;
   localparam int unsigned IndexW  = 3;

   // Size limits of an image
   localparam logic [LenW-1:0] MAX_IMAGE_BYTES = 20'd917504;
   localparam logic [LenW-1:0] MIN_IMAGE_BYTES = 20'd8;

   // Byte positions of the stack pointer and the reset vector
   localparam logic [LenW-1:0] STACK_END  = 20'd4;
   localparam logic [LenW-1:0] VECTOR_END = 20'd8;

   // CRC-32, reflected
   localparam logic [WordW-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [WordW-1:0] CRC_ONES = 32'hFFFF_FFFF;

   // Register reset values
   localparam logic [WordW-1:0] RESET_EXPECTED_CRC = 32'h0000_0000;
   localparam logic [WordW-1:0] RESET_LOAD_ADDR    = 32'h1002_0000;
   localparam logic [WordW-1:0] RESET_RAM_LOW      = 32'h2000_0000;
   localparam logic [WordW-1:0] RESET_RAM_HIGH     = 32'h2004_2000;

   // Register indexes
   localparam logic [IndexW-1:0] CSR_IMAGE_LENGTH = 3'd0;
   localparam logic [IndexW-1:0] CSR_EXPECTED_CRC = 3'd1;
   localparam logic [IndexW-1:0] CSR_LOAD_ADDR    = 3'd2;
   localparam logic [IndexW-1:0] CSR_RAM_LOW      = 3'd3;
   localparam logic [IndexW-1:0] CSR_RAM_HIGH     = 3'd4;

   // Verdict codes
   localparam logic [StatusW-1:0] STATUS_OK     = 3'd0;
   localparam logic [StatusW-1:0] STATUS_SIZE   = 3'd1;
   localparam logic [StatusW-1:0] STATUS_STACK  = 3'd2;
   localparam logic [StatusW-1:0] STATUS_VECTOR = 3'd3;
   localparam logic [StatusW-1:0] STATUS_CRC    = 3'd4;

   // Configuration registers as seen by the verdict logic
   typedef struct packed {
      logic [LenW-1:0]  image_length;
      logic [WordW-1:0] expected_crc;
      logic [WordW-1:0] load_addr;
      logic [WordW-1:0] ram_low;
      logic [WordW-1:0] ram_high;
   } cfg_type;

   // Image summary handed to the verdict stage
   typedef struct packed {
      logic [WordW-1:0] crc_acc;
      logic [WordW-1:0] stack_word;
      logic [WordW-1:0] vector_word;
   } snap_type;

   // One byte through the reflected CRC, bit by bit
   function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] c_in,
                                                 input logic [ByteW-1:0] b);
      logic [WordW-1:0] c;
      c = c_in ^ {{(WordW-ByteW){1'b0}}, b};
      for (int k = 0; k < ByteW; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[src/biv_verdict.sv]
// ----------------------------------------------------------------------------
// biv_verdict: image checks
// Works out the status code of a finished image from its summary and the
// configuration; the first failing check in the order size, stack, vector,
// CRC sets the code.
// ----------------------------------------------------------------------------
module biv_verdict (
   input  biv_pkg::cfg_type               cfg,
   input  biv_pkg::snap_type              snap,
   output logic [biv_pkg::StatusW-1:0]    status
);
   import biv_pkg::*;

   logic             size_bad;
   logic             stack_bad;
   logic             vector_bad;
   logic             crc_bad;
   logic [WordW:0]   vec_addr;
   logic [WordW:0]   vec_limit;

   // Individual checks, all in parallel
   always_comb begin
      size_bad   = (cfg.image_length < MIN_IMAGE_BYTES) ||
                   (cfg.image_length > MAX_IMAGE_BYTES);
      stack_bad  = (snap.stack_word < cfg.ram_low) ||
                   (snap.stack_word > cfg.ram_high) ||
                   (snap.stack_word[1:0] != 2'b00);
      // upper bound kept at 33 bits so it cannot wrap
      vec_addr   = {1'b0, snap.vector_word[WordW-1:1], 1'b0};
      vec_limit  = {1'b0, cfg.load_addr} +
                   {{(WordW+1-LenW){1'b0}}, cfg.image_length};
      vector_bad = !snap.vector_word[0] ||
                   (vec_addr < {1'b0, cfg.load_addr}) ||
                   (vec_addr >= vec_limit);
      crc_bad    = (snap.crc_acc ^ CRC_ONES) != cfg.expected_crc;
   end

   // First failing check wins
   always_comb begin
      priority if (size_bad) begin
         status = STATUS_SIZE;
      end else if (stack_bad) begin
         status = STATUS_STACK;
      end else if (vector_bad) begin
         status = STATUS_VECTOR;
      end else if (crc_bad) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

[src/boot_image_verifier_top.sv]
// ----------------------------------------------------------------------------
// boot_image_verifier_top: streaming firmware image check
// Runs CRC-32 over an image byte stream, picks out the stack pointer and the
// reset vector, and reports one verdict per image.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle, back to back, for as long
// as the result side keeps up. Each accepted item goes through the byte-wide
// CRC update in the cycle it is accepted; that unrolled eight-step CRC is the
// longest path. The item that completes an image yields its verdict on the
// result port through the check stage register and then the output register.
// A verdict waiting on the output does not stop the stream; only when both
// the check stage and the output register hold verdicts does the input
// stall. Start flags a new image; bytes past the configured size, and
// bytes with no image open, are taken and dropped.
module boot_image_verifier_top (
   input  logic                           clock,
   input  logic                           reset,
   // image bytes
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [biv_pkg::ByteW-1:0]      req_data_byte,
   input  logic                           req_start_req,
   // verdicts
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_image_ok,
   output logic [biv_pkg::StatusW-1:0]    rsp_status,
   output logic [biv_pkg::WordW-1:0]      rsp_crc_value,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [biv_pkg::IndexW-1:0]     csr_index,
   input  logic [biv_pkg::WordW-1:0]      csr_write_data
);
   import biv_pkg::*;

   cfg_type             cfg_ff;
   logic [WordW-1:0]    crc_ff, crc_in;
   logic [LenW-1:0]     count_ff, count_in;
   logic [WordW-1:0]    stack_ff, stack_in;
   logic [WordW-1:0]    vector_ff, vector_in;
   logic                finished_ff, finished_in;

   logic                snap_valid_ff;
   snap_type            snap_ff;
   logic                rsp_valid_ff;
   logic                rsp_image_ok_ff;
   logic [StatusW-1:0]  rsp_status_ff;
   logic [WordW-1:0]    rsp_crc_ff;

   logic                accept;
   logic                out_free;
   logic                done;
   logic                absorb;
   logic [WordW-1:0]    crc_0;
   logic [LenW-1:0]     count_0;
   logic                finished_0;
   logic [StatusW-1:0]  status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_length <= MAX_IMAGE_BYTES;
         cfg_ff.expected_crc <= RESET_EXPECTED_CRC;
         cfg_ff.load_addr    <= RESET_LOAD_ADDR;
         cfg_ff.ram_low      <= RESET_RAM_LOW;
         cfg_ff.ram_high     <= RESET_RAM_HIGH;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_LENGTH: cfg_ff.image_length <= csr_write_data[LenW-1:0];
            CSR_EXPECTED_CRC: cfg_ff.expected_crc <= csr_write_data;
            CSR_LOAD_ADDR:    cfg_ff.load_addr    <= csr_write_data;
            CSR_RAM_LOW:      cfg_ff.ram_low      <= csr_write_data;
            CSR_RAM_HIGH:     cfg_ff.ram_high     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !snap_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // Per-byte step: start, absorb, end of image
   always_comb begin
      crc_0      = req_start_req ? CRC_ONES : crc_ff;
      count_0    = req_start_req ? '0 : count_ff;
      stack_in   = req_start_req ? '0 : stack_ff;
      vector_in  = req_start_req ? '0 : vector_ff;
      finished_0 = req_start_req ? 1'b0 : finished_ff;

      absorb   = !finished_0 && (count_0 < cfg_ff.image_length);
      crc_in   = absorb ? crc_byte(crc_0, req_data_byte) : crc_0;
      count_in = absorb ? count_0 + 20'd1 : count_0;

      if (absorb && (count_0 < STACK_END)) begin
         stack_in[{count_0[1:0], 3'b000} +: ByteW] =
            stack_in[{count_0[1:0], 3'b000} +: ByteW] | req_data_byte;
      end
      if (absorb && (count_0 >= STACK_END) && (count_0 < VECTOR_END)) begin
         vector_in[{count_0[1:0], 3'b000} +: ByteW] =
            vector_in[{count_0[1:0], 3'b000} +: ByteW] | req_data_byte;
      end

      done        = !finished_0 && (count_in >= cfg_ff.image_length);
      finished_in = finished_0 || done;
   end

   // Image state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_ONES;
         count_ff    <= '0;
         stack_ff    <= '0;
         vector_ff   <= '0;
         finished_ff <= 1'b1;
      end else if (accept) begin
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         stack_ff    <= stack_in;
         vector_ff   <= vector_in;
         finished_ff <= finished_in;
      end
   end

   // Check stage: summary of a finished image
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (accept && done) begin
         snap_valid_ff <= 1'b1;
      end else if (out_free) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         snap_ff.crc_acc     <= crc_in;
         snap_ff.stack_word  <= stack_in;
         snap_ff.vector_word <= vector_in;
      end
   end

   biv_verdict u_verdict (
      .cfg    (cfg_ff),
      .snap   (snap_ff),
      .status (status)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && snap_valid_ff) begin
         rsp_image_ok_ff <= (status == STATUS_OK);
         rsp_status_ff   <= status;
         rsp_crc_ff      <= snap_ff.crc_acc ^ CRC_ONES;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_image_ok  = rsp_image_ok_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule

[src/biv_checker.sv]
// ----------------------------------------------------------------------------
// biv_checker: port-level checks for the boot image verifier
// Watches the top level's ports and flags verdicts that break the block's
// own rules; bound to the top level below.
// ----------------------------------------------------------------------------
module biv_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_image_ok,
   input  logic [biv_pkg::StatusW-1:0]    rsp_status,
   input  logic [biv_pkg::WordW-1:0]      rsp_crc_value
);
   import biv_pkg::*;

   // No verdict comes out straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("verdict shown right after reset");

   // With the output empty the input is always open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no verdict waiting");

   // The pass flag agrees with the status code
   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_image_ok == (rsp_status == STATUS_OK)))
      else $error("image_ok disagrees with status");

   // Only defined status codes appear
   a_status_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_CRC))
      else $error("undefined status code");

   // A stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_crc_value))
      else $error("verdict changed while stalled");

endmodule

bind boot_image_verifier_top biv_checker u_biv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_image_ok  (rsp_image_ok),
   .rsp_status    (rsp_status),
   .rsp_crc_value (rsp_crc_value)
);
